FILE: hw/rtl/vpt_pkg.sv
package vpt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic {
        REQ_UPSERT = 1'b0,
        REQ_FIND   = 1'b1
    } vpt_req_kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_STALE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } vpt_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_TOTALS,
        S_RESULT
    } vpt_state_t;

    typedef struct packed {
        vpt_req_kind_t       req_type;
        logic [63:0]         account_key;
        logic [63:0]         instrument_key;
        logic [23:0]         currency_code;
        logic signed [23:0]  quantity;
        logic [31:0]         market_price;
        logic [31:0]         average_price;
        logic [31:0]         version;
    } vpt_req_t;

    typedef struct packed {
        vpt_status_t         status;
        logic signed [23:0]  found_quantity;
        logic [31:0]         found_market_price;
        logic [31:0]         found_average_price;
        logic [23:0]         found_currency;
        logic [31:0]         found_version;
        logic [62:0]         gross_exposure;
        logic signed [63:0]  net_exposure;
        logic signed [63:0]  unrealised_pnl;
        logic [31:0]         book_revision;
    } vpt_rsp_t;

    typedef struct packed {
        logic [63:0]         account;
        logic [63:0]         instrument;
        logic signed [23:0]  quantity;
        logic [31:0]         market_price;
        logic [31:0]         average_price;
        logic [23:0]         currency;
        logic [31:0]         version;
    } vpt_entry_t;

    // Totals update command: remove the old entry's share (if any), add the new one
    typedef struct packed {
        logic                start;
        logic                sub_old;
        logic signed [23:0]  old_qty;
        logic [31:0]         old_mp;
        logic [31:0]         old_ap;
        logic signed [23:0]  new_qty;
        logic [31:0]         new_mp;
        logic [31:0]         new_ap;
    } vpt_tot_cmd_t;

    typedef struct packed {
        logic                done;
        logic [63:0]         gross;
        logic signed [63:0]  net;
        logic signed [63:0]  pnl;
    } vpt_tot_stat_t;

endpackage

FILE: hw/rtl/vpt_entry_ram.sv
module vpt_entry_ram (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [vpt_pkg::ADDR_W-1:0]   rd_addr,
    output vpt_pkg::vpt_entry_t          rd_data,
    input  logic                         wr_en,
    input  logic [vpt_pkg::ADDR_W-1:0]   wr_addr,
    input  vpt_pkg::vpt_entry_t          wr_data
);
    import vpt_pkg::*;

    vpt_entry_t mem [CAPACITY];
    vpt_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/vpt_totals.sv
module vpt_totals (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vpt_pkg::vpt_tot_cmd_t   cmd,
    output vpt_pkg::vpt_tot_stat_t  stat
);
    import vpt_pkg::*;

    logic                busy_reg, busy_next;
    logic [1:0]          step_reg, step_next;
    vpt_tot_cmd_t        op_reg, op_next;
    logic signed [56:0]  prod_reg, prod_next;
    logic                prod_valid_reg, prod_valid_next;
    logic [1:0]          prod_step_reg, prod_step_next;
    logic [63:0]         gross_reg, gross_next;
    logic signed [63:0]  net_reg, net_next;
    logic signed [63:0]  pnl_reg, pnl_next;
    logic                done_reg, done_next;

    logic signed [23:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [56:0]  mul_p;
    logic [31:0]         sel_mp;
    logic [31:0]         sel_ap;
    logic signed [63:0]  prod_ext;
    logic [56:0]         prod_mag;
    logic [63:0]         mag_ext;

    // Steps: 0 old value, 1 old P&L, 2 new value, 3 new P&L
    always_comb
    begin
        mul_a  = step_reg[1] ? op_reg.new_qty : op_reg.old_qty;
        sel_mp = step_reg[1] ? op_reg.new_mp : op_reg.old_mp;
        sel_ap = step_reg[1] ? op_reg.new_ap : op_reg.old_ap;
        if (step_reg[0])
        begin
            mul_b = $signed({1'b0, sel_mp}) - $signed({1'b0, sel_ap});
        end
        else
        begin
            mul_b = $signed({1'b0, sel_mp});
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{7{prod_reg[56]}}, prod_reg};
    assign prod_mag = prod_reg[56] ? 57'(-prod_reg) : prod_reg;
    assign mag_ext  = {7'd0, prod_mag};

    always_comb
    begin
        busy_next       = busy_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        prod_next       = prod_reg;
        prod_valid_next = 1'b0;
        prod_step_next  = prod_step_reg;
        gross_next      = gross_reg;
        net_next        = net_reg;
        pnl_next        = pnl_reg;
        done_next       = 1'b0;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd;
            step_next = cmd.sub_old ? 2'd0 : 2'd2;
        end
        else if (busy_reg)
        begin
            prod_next       = mul_p;
            prod_valid_next = 1'b1;
            prod_step_next  = step_reg;
            step_next       = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end

        // Old entry's share is removed, new one added
        if (prod_valid_reg)
        begin
            if (!prod_step_reg[0])
            begin
                if (prod_step_reg[1])
                begin
                    gross_next = gross_reg + mag_ext;
                    net_next   = net_reg + prod_ext;
                end
                else
                begin
                    gross_next = gross_reg - mag_ext;
                    net_next   = net_reg - prod_ext;
                end
            end
            else
            begin
                pnl_next = prod_step_reg[1] ? pnl_reg + prod_ext : pnl_reg - prod_ext;
            end
            done_next = (prod_step_reg == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            step_reg       <= 2'd0;
            prod_valid_reg <= 1'b0;
            prod_step_reg  <= 2'd0;
            gross_reg      <= '0;
            net_reg        <= '0;
            pnl_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            prod_valid_reg <= prod_valid_next;
            prod_step_reg  <= prod_step_next;
            gross_reg      <= gross_next;
            net_reg        <= net_next;
            pnl_reg        <= pnl_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        prod_reg <= prod_next;
    end

    assign stat.done  = done_reg;
    assign stat.gross = gross_reg;
    assign stat.net   = net_reg;
    assign stat.pnl   = pnl_reg;

endmodule

FILE: hw/rtl/vpt_ctrl.sv
module vpt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  vpt_pkg::vpt_req_t            req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output vpt_pkg::vpt_rsp_t            rsp,
    output logic                         ram_rd_en,
    output logic [vpt_pkg::ADDR_W-1:0]   ram_rd_addr,
    input  vpt_pkg::vpt_entry_t          ram_rd_data,
    output logic                         ram_wr_en,
    output logic [vpt_pkg::ADDR_W-1:0]   ram_wr_addr,
    output vpt_pkg::vpt_entry_t          ram_wr_data,
    output vpt_pkg::vpt_tot_cmd_t        tot_cmd,
    input  vpt_pkg::vpt_tot_stat_t       tot_stat
);
    import vpt_pkg::*;

    vpt_state_t          state_reg, state_next;
    vpt_req_t            req_reg, req_next;
    logic                hit_reg, hit_next;
    logic [ADDR_W-1:0]   hit_slot_reg, hit_slot_next;
    vpt_entry_t          hit_entry_reg, hit_entry_next;
    logic [COUNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic                cmp_pending_reg, cmp_pending_next;
    logic [ADDR_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [31:0]         rev_reg, rev_next;
    vpt_status_t         status_reg, status_next;
    vpt_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                accept;
    logic                match;
    logic                last_cmp;
    logic                scan_hit;
    logic                scan_miss;
    logic                full;
    vpt_status_t         decide_status;
    logic                commit;
    logic                rsp_load;
    logic                find_ok;

    assign accept    = req_valid && req_ready;
    assign match     = cmp_pending_reg
                       && (ram_rd_data.account == req_reg.account_key)
                       && (ram_rd_data.instrument == req_reg.instrument_key);
    assign last_cmp  = (COUNT_W'(cmp_idx_reg) + COUNT_W'(1)) == count_reg;
    assign scan_hit  = (state_reg == S_SCAN) && match;
    assign scan_miss = (state_reg == S_SCAN) && cmp_pending_reg && !match && last_cmp;
    assign full      = (count_reg == COUNT_W'(CAPACITY));
    assign rsp_load  = (state_reg == S_RESULT) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        if (req_reg.req_type == REQ_FIND)
        begin
            decide_status = hit_reg ? ST_OK : ST_NOT_FOUND;
        end
        else if ((req_reg.account_key == 64'd0) || (req_reg.instrument_key == 64'd0)
                 || (req_reg.currency_code == 24'd0))
        begin
            decide_status = ST_INVALID;
        end
        else if (hit_reg && (req_reg.version < hit_entry_reg.version))
        begin
            decide_status = ST_STALE;
        end
        else if (!hit_reg && full)
        begin
            decide_status = ST_FULL;
        end
        else
        begin
            decide_status = ST_OK;
        end
    end

    assign commit = (req_reg.req_type == REQ_UPSERT) && (decide_status == ST_OK);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = (state_reg == S_DECIDE && commit) ? S_TOTALS : S_RESULT;
            end
            S_TOTALS:
            begin
                if (tot_stat.done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = issue_idx_reg[ADDR_W-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = hit_reg ? hit_slot_reg : count_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_SCAN:
            begin
                ram_rd_en = (issue_idx_reg < count_reg);
            end
            S_DECIDE:
            begin
                ram_wr_en = commit;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_wr_data.account       = req_reg.account_key;
        ram_wr_data.instrument    = req_reg.instrument_key;
        ram_wr_data.quantity      = req_reg.quantity;
        ram_wr_data.market_price  = req_reg.market_price;
        ram_wr_data.average_price = req_reg.average_price;
        ram_wr_data.currency      = req_reg.currency_code;
        ram_wr_data.version       = req_reg.version;

        tot_cmd.start   = (state_reg == S_DECIDE) && commit;
        tot_cmd.sub_old = hit_reg;
        tot_cmd.old_qty = hit_entry_reg.quantity;
        tot_cmd.old_mp  = hit_entry_reg.market_price;
        tot_cmd.old_ap  = hit_entry_reg.average_price;
        tot_cmd.new_qty = req_reg.quantity;
        tot_cmd.new_mp  = req_reg.market_price;
        tot_cmd.new_ap  = req_reg.average_price;
    end

    assign find_ok = (status_reg == ST_OK) && (req_reg.req_type == REQ_FIND);

    // Datapath
    always_comb
    begin
        req_next         = req_reg;
        hit_next         = hit_reg;
        hit_slot_next    = hit_slot_reg;
        hit_entry_next   = hit_entry_reg;
        issue_idx_next   = issue_idx_reg;
        cmp_pending_next = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        count_next       = count_reg;
        rev_next         = rev_reg;
        status_next      = status_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            req_next       = req;
            hit_next       = 1'b0;
            issue_idx_next = '0;
        end

        if (state_reg == S_SCAN)
        begin
            if (ram_rd_en)
            begin
                cmp_pending_next = 1'b1;
                cmp_idx_next     = issue_idx_reg[ADDR_W-1:0];
                issue_idx_next   = issue_idx_reg + COUNT_W'(1);
            end
            // Hold the matched entry; the next read may already be under way
            if (scan_hit)
            begin
                hit_next         = 1'b1;
                hit_slot_next    = cmp_idx_reg;
                hit_entry_next   = ram_rd_data;
                cmp_pending_next = 1'b0;
            end
            else if (scan_miss)
            begin
                cmp_pending_next = 1'b0;
            end
        end

        if (state_reg == S_DECIDE)
        begin
            status_next = decide_status;
            if (commit)
            begin
                rev_next = rev_reg + 32'd1;
                if (!hit_reg)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end

        if (rsp_load)
        begin
            rsp_valid_next               = 1'b1;
            rsp_next.status              = status_reg;
            rsp_next.found_quantity      = find_ok ? hit_entry_reg.quantity : 24'sd0;
            rsp_next.found_market_price  = find_ok ? hit_entry_reg.market_price : 32'd0;
            rsp_next.found_average_price = find_ok ? hit_entry_reg.average_price : 32'd0;
            rsp_next.found_currency      = find_ok ? hit_entry_reg.currency : 24'd0;
            rsp_next.found_version       = find_ok ? hit_entry_reg.version : 32'd0;
            rsp_next.gross_exposure      = tot_stat.gross[62:0];
            rsp_next.net_exposure        = tot_stat.net;
            rsp_next.unrealised_pnl      = tot_stat.pnl;
            rsp_next.book_revision       = rev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            hit_reg         <= 1'b0;
            issue_idx_reg   <= '0;
            cmp_pending_reg <= 1'b0;
            count_reg       <= '0;
            rev_reg         <= 32'd1;
            status_reg      <= ST_OK;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            hit_reg         <= hit_next;
            issue_idx_reg   <= issue_idx_next;
            cmp_pending_reg <= cmp_pending_next;
            count_reg       <= count_next;
            rev_reg         <= rev_next;
            status_reg      <= status_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hit_slot_reg  <= hit_slot_next;
        hit_entry_reg <= hit_entry_next;
        cmp_idx_reg   <= cmp_idx_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hw/rtl/versioned_position_table_core.sv
// A find or rejected upsert gives its result after a scan of the entries, from 1 up to the
// count stored and at most 64, or with no scan on an empty table; a committed upsert then runs
// the totals update through the shared multiplier, in old value, old P&L, new value and new
// P&L steps when it replaces an entry and in the new steps only when it appends one.
// Throughput: one request at a time, set by the entry memory scan at one read per cycle; the
// next request is taken the cycle after the result is registered, even if it is still waiting.
// Reset clears the table to empty, the totals to zero and the revision to one at once.
module versioned_position_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  vpt_pkg::vpt_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output vpt_pkg::vpt_rsp_t  rsp
);
    import vpt_pkg::*;

    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    vpt_entry_t         ram_rd_data;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    vpt_entry_t         ram_wr_data;
    vpt_tot_cmd_t       tot_cmd;
    vpt_tot_stat_t      tot_stat;

    vpt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .tot_cmd     (tot_cmd),
        .tot_stat    (tot_stat)
    );

    vpt_entry_ram u_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    vpt_totals u_totals (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tot_cmd),
        .stat  (tot_stat)
    );

endmodule

FILE: hw/rtl/vpt_checker.sv
module vpt_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  vpt_pkg::vpt_req_t  req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  vpt_pkg::vpt_rsp_t  rsp
);
    import vpt_pkg::*;

    logic [31:0] last_rev_reg;
    logic [1:0]  outstanding_reg, outstanding_next;
    logic        req_take;
    logic        rsp_take;
    logic [63:0] net_mag;

    assign req_take = req_valid && req_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rev_reg <= 32'd1;
        end
        else if (rsp_take)
        begin
            last_rev_reg <= rsp.book_revision;
        end
    end

    // Count requests accepted whose result has not yet been taken
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (req_take && !rsp_take)
        begin
            outstanding_next = outstanding_reg + 2'd1;
        end
        else if (!req_take && rsp_take)
        begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 2'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    assign net_mag = rsp.net_exposure[63] ? 64'(-rsp.net_exposure) : 64'(rsp.net_exposure);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            (rsp.found_quantity == 24'sd0) && (rsp.found_market_price == 32'd0)
            && (rsp.found_average_price == 32'd0) && (rsp.found_currency == 24'd0)
            && (rsp.found_version == 32'd0))
        else $error("found fields set on a failed request");

    a_rev_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.book_revision == last_rev_reg)
        else $error("revision advanced on a failed request");

    a_gross_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> {1'b0, rsp.gross_exposure} >= net_mag)
        else $error("gross exposure below net magnitude");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (outstanding_reg == 2'd0) || ((outstanding_reg == 2'd1) && rsp_valid))
        else $error("request taken while another is in progress");

endmodule

bind versioned_position_table_core vpt_checker u_vpt_checker (.*);

FILE: bench/tb.sv
module tb;
    import vpt_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int RANDOM_ITEMS = 1880;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    vpt_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    vpt_rsp_t rsp;

    versioned_position_table_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Shadow of the position book
    vpt_entry_t  book [vpt_pkg::CAPACITY];
    int          book_count = 0;
    logic [31:0] book_rev = 32'd1;
    logic [63:0] book_gross = '0;
    logic [63:0] book_net = '0;
    logic [63:0] book_pnl = '0;

    vpt_req_t    queued_requests[$];
    vpt_rsp_t    due_results[$];
    int          req_sent = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          send_gap = 0;
    int          ready_gap = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          cycles = 0;

    logic [63:0] acct_pool [8];
    logic [63:0] instr_pool [10];
    logic [31:0] ver_hint [8][10];

    function automatic vpt_rsp_t apply_to_book(vpt_req_t r);
        vpt_rsp_t res;
        bit       hit;
        int       slot;
        longint   q;
        longint   mp;
        longint   ap;
        longint   prod;
        longint   gross;
        longint   net;
        longint   pnl;
        res = '0;
        hit = 1'b0;
        slot = 0;
        for (int i = 0; i < book_count; i++)
        begin
            if (!hit && book[i].account == r.account_key && book[i].instrument == r.instrument_key)
            begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (r.req_type == REQ_FIND)
        begin
            if (hit)
            begin
                res.status              = ST_OK;
                res.found_quantity      = book[slot].quantity;
                res.found_market_price  = book[slot].market_price;
                res.found_average_price = book[slot].average_price;
                res.found_currency      = book[slot].currency;
                res.found_version       = book[slot].version;
            end
            else
                res.status = ST_NOT_FOUND;
        end
        else if (r.account_key == 64'd0 || r.instrument_key == 64'd0 || r.currency_code == 24'd0)
            res.status = ST_INVALID;
        else if (hit && r.version < book[slot].version)
            res.status = ST_STALE;
        else if (!hit && book_count >= vpt_pkg::CAPACITY)
            res.status = ST_FULL;
        else
        begin
            if (!hit)
            begin
                slot = book_count;
                book_count++;
            end
            book[slot] = '{r.account_key, r.instrument_key, r.quantity, r.market_price,
                           r.average_price, r.currency_code, r.version};
            book_rev = book_rev + 32'd1;
            gross = 0;
            net = 0;
            pnl = 0;
            for (int i = 0; i < book_count; i++)
            begin
                q = {{40{book[i].quantity[23]}}, book[i].quantity};
                mp = {32'd0, book[i].market_price};
                ap = {32'd0, book[i].average_price};
                prod = q * mp;
                gross += (prod < 0) ? -prod : prod;
                net += prod;
                pnl += q * (mp - ap);
            end
            book_gross = gross;
            book_net = net;
            book_pnl = pnl;
            res.status = ST_OK;
        end
        res.gross_exposure = book_gross[62:0];
        res.net_exposure   = book_net;
        res.unrealised_pnl = book_pnl;
        res.book_revision  = book_rev;
        return res;
    endfunction

    function automatic int pick_idle();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        else if (p < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic vpt_req_t make_request(vpt_req_kind_t kind, logic [63:0] acc,
                                              logic [63:0] ins, logic [23:0] cur,
                                              logic [23:0] qty, logic [31:0] mp,
                                              logic [31:0] ap, logic [31:0] ver);
        vpt_req_t r;
        r.req_type       = kind;
        r.account_key    = acc;
        r.instrument_key = ins;
        r.currency_code  = cur;
        r.quantity       = qty;
        r.market_price   = mp;
        r.average_price  = ap;
        r.version        = ver;
        return r;
    endfunction

    function automatic vpt_req_t next_random_request(int idx);
        vpt_req_t    r;
        int          a;
        int          n;
        int          p;
        logic [31:0] hint;
        a = $urandom_range(0, 7);
        // widen the key set later on so that the book fills up
        n = $urandom_range(0, idx < 600 ? 4 : 9);
        r.req_type       = REQ_UPSERT;
        r.account_key    = acct_pool[a];
        r.instrument_key = instr_pool[n];
        r.currency_code  = 24'($urandom_range(1, 24'hFFFFFF));
        r.quantity       = 24'($urandom);
        if ($urandom_range(0, 15) == 0)
            r.quantity = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        r.market_price  = $urandom;
        r.average_price = ($urandom_range(0, 7) == 0) ? r.market_price : $urandom;
        hint = ver_hint[a][n];
        p = $urandom_range(0, 99);
        if (p < 80)
            r.version = (hint > 32'hFFFF_FFF0) ? hint : hint + 32'($urandom_range(0, 3));
        else if (p < 90)
            r.version = hint - 32'($urandom_range(1, 5));
        else
            r.version = $urandom;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            if (r.version > hint)
                ver_hint[a][n] = r.version;
        end
        else if (p < 85)
            r.req_type = REQ_FIND;
        else if (p < 90)
        begin
            r.req_type       = REQ_FIND;
            r.account_key    = {$urandom, $urandom};
            r.instrument_key = {$urandom, $urandom};
        end
        else if (p < 94)
        begin
            case ($urandom_range(0, 2))
                0: r.account_key = '0;
                1: r.instrument_key = '0;
                default: r.currency_code = '0;
            endcase
        end
        else if (p < 97)
        begin
            r.account_key    = {$urandom, $urandom} | 64'd1;
            r.instrument_key = {$urandom, $urandom} | 64'd1;
        end
        else
        begin
            r.req_type = REQ_FIND;
            case ($urandom_range(0, 2))
                0: r.account_key = '0;
                1: r.instrument_key = '0;
                default:
                begin
                    r.account_key = '0;
                    r.instrument_key = '0;
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s expected %h got %h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sender
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                due_results.push_back(apply_to_book(req));
                req_sent <= req_sent + 1;
            end
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap  <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0)
                begin
                    req       <= queued_requests.pop_front();
                    req_valid <= 1'b1;
                    send_gap  <= ((req_sent / 250) % 4 == 2) ? 0 : pick_idle();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        vpt_rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen <= results_seen + 1;
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with none expected, got %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.status !== want.status)
                        report_field("status", want.status, rsp.status);
                    if (rsp.found_quantity !== want.found_quantity)
                        report_field("found_quantity", want.found_quantity, rsp.found_quantity);
                    if (rsp.found_market_price !== want.found_market_price)
                        report_field("found_market_price", want.found_market_price,
                                     rsp.found_market_price);
                    if (rsp.found_average_price !== want.found_average_price)
                        report_field("found_average_price", want.found_average_price,
                                     rsp.found_average_price);
                    if (rsp.found_currency !== want.found_currency)
                        report_field("found_currency", want.found_currency, rsp.found_currency);
                    if (rsp.found_version !== want.found_version)
                        report_field("found_version", want.found_version, rsp.found_version);
                    if (rsp.gross_exposure !== want.gross_exposure)
                        report_field("gross_exposure", want.gross_exposure, rsp.gross_exposure);
                    if (rsp.net_exposure !== want.net_exposure)
                        report_field("net_exposure", want.net_exposure, rsp.net_exposure);
                    if (rsp.unrealised_pnl !== want.unrealised_pnl)
                        report_field("unrealised_pnl", want.unrealised_pnl, rsp.unrealised_pnl);
                    if (rsp.book_revision !== want.book_revision)
                        report_field("book_revision", want.book_revision, rsp.book_revision);
                end
            end
            // hold off once for a long stretch so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 400)
            begin
                hold_left <= 300;
                hold_done <= 1'b1;
                rsp_ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap <= ready_gap - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                ready_gap <= ((results_seen / 300) % 4 == 1) ? 0 : pick_idle();
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("versioned_position_table_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        for (int i = 0; i < 8; i++)
            acct_pool[i] = {$urandom, $urandom} | 64'd1;
        for (int i = 0; i < 10; i++)
            instr_pool[i] = {$urandom, $urandom} | 64'd1;
        acct_pool[3]  = 64'hFFFF_FFFF_FFFF_FFFF;
        instr_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 10; j++)
                ver_hint[i][j] = '0;

        // lookups on an empty book, zero-key lookup
        queued_requests.push_back(make_request(REQ_FIND, acct_pool[0], instr_pool[0],
                                               24'h1, 24'h0, 32'h0, 32'h0, 32'h0));
        queued_requests.push_back(make_request(REQ_FIND, 64'd0, 64'd0,
                                               24'h0, 24'h0, 32'h0, 32'h0, 32'h0));
        // invalid upserts: zero account, zero instrument, zero currency
        queued_requests.push_back(make_request(REQ_UPSERT, 64'd0, instr_pool[0],
                                               24'h555555, 24'h1, 32'h10000, 32'h10000, 32'h1));
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[0], 64'd0,
                                               24'h555555, 24'h1, 32'h10000, 32'h10000, 32'h1));
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[0], instr_pool[0],
                                               24'h0, 24'h1, 32'h10000, 32'h10000, 32'h1));
        // field extremes
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[0], instr_pool[0],
                                               24'hFFFFFF, 24'h7FFFFF, 32'hFFFF_FFFF,
                                               32'h0, 32'd5));
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[1], instr_pool[1],
                                               24'h000001, 24'h800000, 32'hFFFF_FFFF,
                                               32'hFFFF_FFFF, 32'd0));
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[2], instr_pool[2],
                                               24'h414243, 24'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[3], instr_pool[3],
                                               24'hAAAAAA, 24'h800000, 32'h0,
                                               32'hFFFF_FFFF, 32'd7));
        queued_requests.push_back(make_request(REQ_FIND, acct_pool[0], instr_pool[0],
                                               24'h0, 24'h0, 32'h0, 32'h0, 32'h0));
        // stale, then equal version accepted
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[0], instr_pool[0],
                                               24'h123456, 24'h3, 32'h1, 32'h1, 32'd4));
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[0], instr_pool[0],
                                               24'h123456, 24'hFFFFFF, 32'h1,
                                               32'hFFFF_FFFF, 32'd5));
        queued_requests.push_back(make_request(REQ_FIND, acct_pool[0], instr_pool[0],
                                               24'h0, 24'h0, 32'h0, 32'h0, 32'h0));
        queued_requests.push_back(make_request(REQ_UPSERT, acct_pool[2], instr_pool[2],
                                               24'h414243, 24'h5, 32'h5, 32'h5, 32'hFFFF_FFFE));
        queued_requests.push_back(make_request(REQ_FIND, acct_pool[1], instr_pool[1],
                                               24'h0, 24'h0, 32'h0, 32'h0, 32'h0));
        queued_requests.push_back(make_request(REQ_FIND, acct_pool[3], instr_pool[3],
                                               24'h0, 24'h0, 32'h0, 32'h0, 32'h0));
        // account matches one entry, instrument another
        queued_requests.push_back(make_request(REQ_FIND, acct_pool[0], instr_pool[2],
                                               24'h0, 24'h0, 32'h0, 32'h0, 32'h0));
        queued_requests.push_back(make_request(REQ_FIND, acct_pool[2], 64'd0,
                                               24'h0, 24'h0, 32'h0, 32'h0, 32'h0));
        ver_hint[0][0] = 32'd5;
        ver_hint[2][2] = 32'hFFFF_FFFF;
        ver_hint[3][3] = 32'd7;

        for (int i = 0; i < RANDOM_ITEMS; i++)
            queued_requests.push_back(next_random_request(i));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || req_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0 && due_results.size() == 0)
            $display("versioned_position_table_core: match");
        else
            $display("versioned_position_table_core: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/vpt_pkg.sv
hw/rtl/vpt_entry_ram.sv
hw/rtl/vpt_totals.sv
hw/rtl/vpt_ctrl.sv
hw/rtl/versioned_position_table_core.sv
hw/rtl/vpt_checker.sv
bench/tb.sv
